>>> rtl/rgb_to_cielab_converter_top_assert.svh
// Assertion macros shared by the converter's checker.
`ifndef RGB_TO_CIELAB_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_CIELAB_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define RGBLAB_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("rgblab assertion failed");

// Next-cycle implication, ignored while reset is high.
`define RGBLAB_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("rgblab assertion failed");

// Next-cycle implication that also holds through reset.
`define RGBLAB_ASSERT_ALWAYS_NEXT(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("rgblab assertion failed");

`endif

>>> rtl/rgblab_pkg.sv
// Shared constants, types and the linearization table of the RGB to CIELAB converter.
package rgblab_pkg;

  localparam int PIX_W = 8;
  localparam int LIN_W = 17;
  localparam int NORM_W = 17;
  localparam int COEF_W = 24;
  localparam int PROD_W = 40;
  localparam int SUM_W = 40;
  localparam int MIX_SHIFT = 14;

  localparam int CDIV_LAT = 3;
  localparam int MIX_LAT = 3 + CDIV_LAT;

  localparam int F_W = 21;
  localparam int CBRT_LAT = F_W;
  localparam int CBRT_PRESHIFT = 44;
  localparam int FMAP_LAT = CBRT_LAT + 1;

  localparam int KNEE_W = 10;
  localparam int F_KNEE = 14155776 / 24389;
  localparam int F_SLOPE = 24389 * 16;
  localparam int F_OFFSET = 432 * (1 << 20);
  localparam int F_DIV = 3132;
  localparam int LINF_N_W = 30;
  localparam int LINF_Q_W = 19;
  localparam int LIN_PAD = CBRT_LAT - 1 - CDIV_LAT;

  localparam int OUT_LAT = 2;
  localparam int PIPE_LAT = MIX_LAT + FMAP_LAT + OUT_LAT;

  localparam int DEFAULT_FRAC_BITS = 8;
  localparam int RND_SHIFT = 20;
  localparam int L_GAIN = 116;
  localparam int L_OFFSET = 16 * (1 << 20);
  localparam int A_GAIN = 500;
  localparam int B_GAIN = 200;
  localparam int LAB_L_W = 15;
  localparam int LAB_AX_W = 16;
  localparam int AX_LIMIT = 32767;

  localparam logic [COEF_W-1:0] MIX_COEF [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339, 24'd1191920, 24'd9503041}
  };
  localparam longint unsigned MIX_DIV [3] = '{64'd9504500, 64'd10000000, 64'd10889170};
  localparam logic [SUM_W-1:0] MIX_HALF [3] = '{
    SUM_W'(64'd9504500 / 2), SUM_W'(64'd10000000 / 2), SUM_W'(64'd10889170 / 2)
  };

  typedef logic [LIN_W-1:0] lin_table_t [256];

  function automatic lin_table_t build_lin_table();
    lin_table_t tbl;
    real x;
    for (int i = 0; i < 256; i++) begin
      x = real'(i) / 255.0;
      tbl[i] = LIN_W'($rtoi(65536.0 * (x ** 2.2) + 0.5));
    end
    return tbl;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

  typedef struct packed {
    logic [LAB_L_W-1:0] lightness;
    logic signed [LAB_AX_W-1:0] green_red_axis;
    logic signed [LAB_AX_W-1:0] blue_yellow_axis;
  } lab_t;

endpackage

>>> rtl/rgblab_ifs.sv
// Valid/ready channel interfaces for the pixel input and the Lab result.
interface rgblab_pixel_if
  import rgblab_pkg::*;
();
  logic valid;
  logic ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgblab_lab_if
  import rgblab_pkg::*;
();
  logic valid;
  logic ready;
  logic [LAB_L_W-1:0] lightness;
  logic signed [LAB_AX_W-1:0] green_red_axis;
  logic signed [LAB_AX_W-1:0] blue_yellow_axis;
  modport source (output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink (input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface

>>> rtl/rgblab_cdiv.sv
// Three-stage rounded-down division by a constant using a reciprocal and one correction.
module rgblab_cdiv #(
  parameter int N_W = 40,
  parameter int Q_W = 17,
  parameter int SHIFT = 14,
  parameter longint unsigned DIVISOR = 3
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  output logic [Q_W-1:0] quot
);
  localparam int RECIP_SHIFT = 32;
  localparam logic [63:0] RECIP = (64'd1 << (RECIP_SHIFT + SHIFT)) / DIVISOR;
  localparam int M_W = $clog2(RECIP + 1);
  localparam int D_W = $clog2(DIVISOR + 1);
  localparam int T_W = N_W - SHIFT;
  localparam int E_W = T_W + M_W;
  localparam int P_W = Q_W + D_W;

  logic [E_W-1:0] est_full;
  logic [Q_W-1:0] est;
  logic [Q_W-1:0] est_d;
  logic [N_W-1:0] num_d1;
  logic [N_W-1:0] num_d2;
  logic [P_W-1:0] back;
  logic [N_W-1:0] rem;

  assign est_full = E_W'(num[N_W-1:SHIFT]) * E_W'(RECIP[M_W-1:0]);
  assign rem = num_d2 - N_W'(back);

  always_ff @(posedge clk) begin
    if (en) begin
      est <= Q_W'(est_full >> RECIP_SHIFT);
      num_d1 <= num;
      back <= P_W'(est) * P_W'(DIVISOR);
      est_d <= est;
      num_d2 <= num_d1;
      quot <= est_d + Q_W'(rem >= N_W'(DIVISOR));
    end
  end
endmodule

>>> rtl/rgblab_mix.sv
// Linearization lookup and the RGB to white-normalized XYZ matrix.
module rgblab_mix
  import rgblab_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [PIX_W-1:0]  red,
  input  logic [PIX_W-1:0]  green,
  input  logic [PIX_W-1:0]  blue,
  output logic [NORM_W-1:0] xyz [3]
);
  logic [LIN_W-1:0] lin [3];
  logic [PROD_W-1:0] prod [3][3];
  logic [SUM_W-1:0] sum [3];

  always_ff @(posedge clk) begin
    if (en) begin
      lin[0] <= LIN_TABLE[red];
      lin[1] <= LIN_TABLE[green];
      lin[2] <= LIN_TABLE[blue];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PROD_W'(lin[c]) * PROD_W'(MIX_COEF[r][c]);
        end
        sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]) + MIX_HALF[r];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    rgblab_cdiv #(
      .N_W(SUM_W),
      .Q_W(NORM_W),
      .SHIFT(MIX_SHIFT),
      .DIVISOR(MIX_DIV[g])
    ) u_div (
      .clk(clk),
      .en(en),
      .num(sum[g]),
      .quot(xyz[g])
    );
  end
endmodule

>>> rtl/rgblab_cbrt.sv
// Pipelined integer cube root, one result bit per stage.
module rgblab_cbrt
  import rgblab_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NORM_W-1:0] v,
  output logic [F_W-1:0]    root
);
  localparam int X_W = 3 * CBRT_LAT;
  localparam int Y2_W = 2 * F_W;
  localparam int B_W = Y2_W + 2;

  logic [X_W-1:0] st_x [CBRT_LAT];
  logic [F_W-1:0] st_y [CBRT_LAT];
  logic [Y2_W-1:0] st_y2 [CBRT_LAT];

  for (genvar k = 0; k < CBRT_LAT; k++) begin : g_stage
    localparam int SH = X_W - 3 * (k + 1);
    logic [X_W-1:0] xi;
    logic [F_W-1:0] yi;
    logic [F_W-1:0] yd;
    logic [Y2_W-1:0] y2i;
    logic [Y2_W-1:0] y2d;
    logic [B_W-1:0] base;
    logic [B_W-1:0] trial;
    logic take;

    if (k == 0) begin : g_first
      assign xi = X_W'(v) << CBRT_PRESHIFT;
      assign yi = '0;
      assign y2i = '0;
    end else begin : g_next
      assign xi = st_x[k-1];
      assign yi = st_y[k-1];
      assign y2i = st_y2[k-1];
    end

    assign yd = yi << 1;
    assign y2d = y2i << 2;
    assign base = B_W'(y2d) + B_W'(yd);
    assign trial = (base << 1) + base + B_W'(1);
    assign take = (xi >> SH) >= X_W'(trial);

    always_ff @(posedge clk) begin
      if (en) begin
        st_x[k] <= take ? xi - (X_W'(trial) << SH) : xi;
        st_y[k] <= yd | F_W'(take);
        st_y2[k] <= take ? y2d + (Y2_W'(yd) << 1) + Y2_W'(1) : y2d;
      end
    end
  end

  assign root = st_y[CBRT_LAT-1];
endmodule

>>> rtl/rgblab_fmap.sv
// CIE f function: linear segment below the knee, cube root above it.
module rgblab_fmap
  import rgblab_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NORM_W-1:0] v,
  output logic [F_W-1:0]    f
);
  logic [LINF_N_W-1:0] lin_num;
  logic [LINF_Q_W-1:0] lin_q;
  logic [LINF_Q_W-1:0] lin_dly [LIN_PAD];
  logic knee [CBRT_LAT];
  logic [F_W-1:0] root;

  always_ff @(posedge clk) begin
    if (en) begin
      lin_num <= LINF_N_W'(v[KNEE_W-1:0]) * LINF_N_W'(F_SLOPE) + LINF_N_W'(F_OFFSET);
      knee[0] <= (v <= NORM_W'(F_KNEE));
      for (int i = 1; i < CBRT_LAT; i++) begin
        knee[i] <= knee[i-1];
      end
      lin_dly[0] <= lin_q;
      for (int i = 1; i < LIN_PAD; i++) begin
        lin_dly[i] <= lin_dly[i-1];
      end
      f <= knee[CBRT_LAT-1] ? F_W'(lin_dly[LIN_PAD-1]) : root;
    end
  end

  rgblab_cdiv #(
    .N_W(LINF_N_W),
    .Q_W(LINF_Q_W),
    .SHIFT(0),
    .DIVISOR(F_DIV)
  ) u_lin_div (
    .clk(clk),
    .en(en),
    .num(lin_num),
    .quot(lin_q)
  );

  rgblab_cbrt u_cbrt (
    .clk(clk),
    .en(en),
    .v(v),
    .root(root)
  );
endmodule

>>> rtl/rgblab_out.sv
// Forms L*, a*, b* from the f values, then rounds and saturates them.
module rgblab_out
  import rgblab_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input  logic           clk,
  input  logic           en,
  input  logic [F_W-1:0] fx,
  input  logic [F_W-1:0] fy,
  input  logic [F_W-1:0] fz,
  output lab_t           lab_q
);
  localparam int PW = 32;
  localparam int RW = PW + FRAC_BITS;
  localparam int L_FULL = 100 << FRAC_BITS;
  localparam int L_TOP = (L_FULL > 32767) ? 32767 : L_FULL;
  localparam logic signed [RW-1:0] HALF = RW'(longint'(1) << (RND_SHIFT - 1));
  localparam logic signed [RW-1:0] L_MAX = RW'(L_TOP);
  localparam logic signed [RW-1:0] AX_MAX = RW'(AX_LIMIT);
  localparam logic signed [RW-1:0] AX_MIN = RW'(-AX_LIMIT - 1);

  logic signed [PW-1:0] sx, sy, sz;
  logic signed [PW-1:0] l_p, a_p, b_p;
  logic signed [RW-1:0] l_r, a_r, b_r;
  lab_t lab_next;

  assign sx = PW'(fx);
  assign sy = PW'(fy);
  assign sz = PW'(fz);

  assign l_r = ((RW'(l_p) <<< FRAC_BITS) + HALF) >>> RND_SHIFT;
  assign a_r = ((RW'(a_p) <<< FRAC_BITS) + HALF) >>> RND_SHIFT;
  assign b_r = ((RW'(b_p) <<< FRAC_BITS) + HALF) >>> RND_SHIFT;

  always_comb begin
    if (l_r[RW-1]) begin
      lab_next.lightness = '0;
    end else if (l_r > L_MAX) begin
      lab_next.lightness = LAB_L_W'(L_TOP);
    end else begin
      lab_next.lightness = l_r[LAB_L_W-1:0];
    end
    if (a_r < AX_MIN) begin
      lab_next.green_red_axis = LAB_AX_W'(AX_MIN);
    end else if (a_r > AX_MAX) begin
      lab_next.green_red_axis = LAB_AX_W'(AX_MAX);
    end else begin
      lab_next.green_red_axis = LAB_AX_W'(a_r);
    end
    if (b_r < AX_MIN) begin
      lab_next.blue_yellow_axis = LAB_AX_W'(AX_MIN);
    end else if (b_r > AX_MAX) begin
      lab_next.blue_yellow_axis = LAB_AX_W'(AX_MAX);
    end else begin
      lab_next.blue_yellow_axis = LAB_AX_W'(b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_p <= sy * PW'(L_GAIN) - PW'(L_OFFSET);
      a_p <= (sx - sy) * PW'(A_GAIN);
      b_p <= (sy - sz) * PW'(B_GAIN);
      lab_q <= lab_next;
    end
  end
endmodule

>>> rtl/rgb_to_cielab_converter_top.sv
// Top level of the sRGB to CIELAB (D65) pixel converter.
//
// The pixel channel takes one 8-bit red, green, blue code per item. The lab
// channel returns L*, a*, b* scaled by 2^FRAC_BITS, rounded and saturated.
// Both channels move an item on a clock edge with valid and ready high.
// The converter takes one item per cycle while its pipeline is not frozen.
// A result passes through linearization and the matrix with its divisions,
// the f function with its 21-stage cube root, the registers that form and
// saturate the outputs, and the output register.
// A synchronous reset clears all valid bits, the output valid too; data
// in flight is dropped. When the receiver holds ready low, the result stays
// on the port, one more item moves into a spare register, and then the
// pipeline freezes and pixel ready goes low until the receiver takes an item.
module rgb_to_cielab_converter_top
  import rgblab_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input logic          clk,
  input logic          rst,
  rgblab_pixel_if.sink pixel,
  rgblab_lab_if.source lab
);
  logic en;
  logic push;
  logic [PIPE_LAT-1:0] vld;
  logic [NORM_W-1:0] xyz [3];
  logic [F_W-1:0] fv [3];
  lab_t pipe_data;
  lab_t out_data;
  lab_t spare_data;
  logic out_valid;
  logic spare_valid;

  assign en = !vld[PIPE_LAT-1] || !spare_valid;
  assign push = vld[PIPE_LAT-1] && !spare_valid;
  assign pixel.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], pixel.valid};
    end
  end

  rgblab_mix u_mix (
    .clk(clk),
    .en(en),
    .red(pixel.red),
    .green(pixel.green),
    .blue(pixel.blue),
    .xyz(xyz)
  );

  for (genvar g = 0; g < 3; g++) begin : g_fmap
    rgblab_fmap u_fmap (
      .clk(clk),
      .en(en),
      .v(xyz[g]),
      .f(fv[g])
    );
  end

  rgblab_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk(clk),
    .en(en),
    .fx(fv[0]),
    .fy(fv[1]),
    .fz(fv[2]),
    .lab_q(pipe_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || lab.ready) begin
      if (spare_valid) begin
        out_valid <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || lab.ready) begin
      if (spare_valid) begin
        out_data <= spare_data;
      end else if (push) begin
        out_data <= pipe_data;
      end
    end else if (push) begin
      spare_data <= pipe_data;
    end
  end

  assign lab.valid = out_valid;
  assign lab.lightness = out_data.lightness;
  assign lab.green_red_axis = out_data.green_red_axis;
  assign lab.blue_yellow_axis = out_data.blue_yellow_axis;
endmodule

>>> rtl/rgblab_checker.sv
// Port-level checker for the converter, bound to the top level.
`include "rgb_to_cielab_converter_top_assert.svh"

module rgblab_checker
  import rgblab_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [LAB_L_W-1:0]         lightness,
  input logic signed [LAB_AX_W-1:0] green_red_axis,
  input logic signed [LAB_AX_W-1:0] blue_yellow_axis
);
  localparam int L_FULL = 100 << FRAC_BITS;
  localparam int L_TOP = (L_FULL > 32767) ? 32767 : L_FULL;

  // The input is only held off while a result is waiting at the output.
  `RGBLAB_ASSERT_IMPLY(a_ready_only_when_full, clk, rst, !in_ready, out_valid)
  `RGBLAB_ASSERT_IMPLY(a_lightness_range, clk, rst, out_valid, lightness <= LAB_L_W'(L_TOP))
  `RGBLAB_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)
  `RGBLAB_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready && !in_valid, out_valid && $stable(lightness) && $stable(green_red_axis) && $stable(blue_yellow_axis))
endmodule

bind rgb_to_cielab_converter_top rgblab_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_rgblab_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(pixel.valid),
  .in_ready(pixel.ready),
  .out_valid(lab.valid),
  .out_ready(lab.ready),
  .lightness(lab.lightness),
  .green_red_axis(lab.green_red_axis),
  .blue_yellow_axis(lab.blue_yellow_axis)
);
